@@ src/sst_pkg.sv @@
//------------------------------------------------------------------------------
// sst_pkg
// Shared request and status codes, the per-cell command bundle and the
// note assignment rule for the sample slice table.
//------------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    localparam int MAX_SLICES_DEF = 64;
    localparam int NOTE_MAX       = 127;
    localparam int MIN_SPAN       = 64;
    localparam int ROOT_RESET     = 36;

    // request kinds
    localparam logic [2:0] REQ_CREATE  = 3'd0;
    localparam logic [2:0] REQ_DELETE  = 3'd1;
    localparam logic [2:0] REQ_CLEAR   = 3'd2;
    localparam logic [2:0] REQ_DEFAULT = 3'd3;
    localparam logic [2:0] REQ_LOOKUP  = 3'd4;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_IGNORED   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic append;   // write the slot addressed by wr_slot
        logic remove;   // close the gap left by del_slot
        logic rotate;   // notes move one cell toward cell 0
    } cell_cmd_t;

    // note of slot idx: root + idx, saturating at the top note
    function automatic logic [6:0] note_for(input logic [6:0] root, input logic [7:0] idx);
        logic [8:0] sum;
        sum = 9'(root) + 9'(idx);
        return (sum > 9'(NOTE_MAX)) ? 7'(NOTE_MAX) : sum[6:0];
    endfunction

endpackage

`default_nettype wire

@@ src/sst_cell.sv @@
//------------------------------------------------------------------------------
// sst_cell
// One slot of the slice table: start, end and note, loaded from the write
// bus, from the upper neighbor on a delete, or rotated during a lookup.
//------------------------------------------------------------------------------
`default_nettype none

module sst_cell #(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  wire                   aclk,
    input  sst_pkg::cell_cmd_t    cmd,
    input  wire  [CNT_W-1:0]      wr_slot,
    input  wire  [CNT_W-1:0]      del_slot,
    input  wire  [CNT_W-1:0]      count,
    input  wire  [6:0]            root_note,
    input  wire  [30:0]           wr_start,
    input  wire  [30:0]           wr_end,
    input  wire  [30:0]           nb_start,
    input  wire  [30:0]           nb_end,
    input  wire  [6:0]            nb_note,
    output logic [30:0]           start_q,
    output logic [30:0]           end_q,
    output logic [6:0]            note_q
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] NXT_C = CNT_W'(INDEX + 1);

    logic [30:0] start_reg, start_next;
    logic [30:0] end_reg, end_next;
    logic [6:0]  note_reg, note_next;
    logic [6:0]  own_note;

    assign own_note = sst_pkg::note_for(root_note, 8'(INDEX));

    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        note_next  = note_reg;
        if (cmd.append && (wr_slot == IDX_C)) begin
            start_next = wr_start;
            end_next   = wr_end;
            note_next  = own_note;
        end else if (cmd.remove && (IDX_C >= del_slot) && (NXT_C < count)) begin
            // shifted entries take a fresh note from the current root
            start_next = nb_start;
            end_next   = nb_end;
            note_next  = own_note;
        end else if (cmd.rotate) begin
            note_next  = nb_note;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        end_reg   <= end_next;
        note_reg  <= note_next;
    end

    assign start_q = start_reg;
    assign end_q   = end_reg;
    assign note_q  = note_reg;

endmodule

`default_nettype wire

@@ src/sample_slice_table_unit.sv @@
//------------------------------------------------------------------------------
// sample_slice_table_unit
// Slice table built as a ring of slot cells with a small request sequencer.
//
//  channel   dir  handshake             payload
//  s_*       in   s_valid / s_ready     req_type, start_pos, end_pos,
//                                       slice_index, sample_length, note
//  m_*       out  m_valid / m_ready     status, result_index, result_note,
//                                       slice_total, selection_valid,
//                                       selected_index
//  cfg_*     in   cfg_we                cfg_wdata -> root note
//
// Create, delete, clear, create default and unknown requests pass through
// the execute and done states to the result register; a delete shifts every
// cell at or above the deleted slot at once. A note lookup rotates the notes
// once around the cell ring in the scan state, comparing cell 0 each cycle.
// One beat in flight: s_ready is high only while idle, but a new beat is
// taken while the previous result still waits in the output register.
// A finished result waits internally while m_valid is high and m_ready low.
// Reset empties the table and drops the selection; slot contents are not
// cleared, only entries below the count are ever read.
//------------------------------------------------------------------------------
`default_nettype none

module sample_slice_table_unit #(
    parameter int MAX_SLICES = sst_pkg::MAX_SLICES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [6:0]  cfg_wdata,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_req_type,
    input  wire  [29:0] s_start_pos,
    input  wire  [29:0] s_end_pos,
    input  wire  [5:0]  s_slice_index,
    input  wire  [29:0] s_sample_length,
    input  wire  [6:0]  s_note,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_status,
    output logic [5:0]  m_result_index,
    output logic [6:0]  m_result_note,
    output logic [6:0]  m_slice_total,
    output logic        m_selection_valid,
    output logic [5:0]  m_selected_index
);

    localparam int CNT_W = $clog2(MAX_SLICES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SLICES);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(MAX_SLICES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [6:0]       root_reg, root_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] sel_slot_reg, sel_slot_next;
    logic             sel_flag_reg, sel_flag_next;
    logic [CNT_W-1:0] scan_reg, scan_next;

    // captured request
    logic [2:0]  req_type_reg, req_type_next;
    logic [29:0] req_start_reg, req_start_next;
    logic [29:0] req_end_reg, req_end_next;
    logic [5:0]  req_index_reg, req_index_next;
    logic [29:0] req_len_reg, req_len_next;
    logic [6:0]  req_note_reg, req_note_next;

    // finished result waiting for the output register
    logic [1:0] pend_status_reg, pend_status_next;
    logic [5:0] pend_idx_reg, pend_idx_next;
    logic [6:0] pend_note_reg, pend_note_next;

    logic       m_valid_reg, m_valid_next;
    logic [1:0] m_status_reg, m_status_next;
    logic [5:0] m_idx_reg, m_idx_next;
    logic [6:0] m_note_reg, m_note_next;
    logic [6:0] m_total_reg, m_total_next;
    logic       m_sel_valid_reg, m_sel_valid_next;
    logic [5:0] m_sel_idx_reg, m_sel_idx_next;

    // interval normalization for create and create default
    logic        is_default;
    logic [29:0] src_s, src_e, span;
    logic        short_span;
    logic [30:0] wr_start, wr_end;

    sst_pkg::cell_cmd_t cmd;
    logic [CNT_W-1:0]   wr_slot, del_slot, new_cnt;
    logic               s_fire;
    logic [6:0]         cell_note  [MAX_SLICES];
    logic [30:0]        cell_start [MAX_SLICES];
    logic [30:0]        cell_end   [MAX_SLICES];

    assign s_fire     = s_valid && s_ready;
    assign s_ready    = (state_reg == S_IDLE);
    assign is_default = (req_type_reg == sst_pkg::REQ_DEFAULT);
    assign src_s      = is_default ? 30'd0 : req_start_reg;
    assign src_e      = is_default ? req_len_reg : req_end_reg;
    assign span       = (src_e >= src_s) ? (src_e - src_s) : (src_s - src_e);
    assign short_span = (span < 30'(sst_pkg::MIN_SPAN));
    assign del_slot   = CNT_W'(req_index_reg);
    assign new_cnt    = count_reg - CNT_W'(1);
    assign wr_slot    = is_default ? '0 : count_reg;

    always_comb begin
        if (short_span) begin
            wr_start = 31'(src_s);
            wr_end   = 31'(src_s) + 31'(sst_pkg::MIN_SPAN);
        end else if (src_s > src_e) begin
            wr_start = 31'(src_e);
            wr_end   = 31'(src_s);
        end else begin
            wr_start = 31'(src_s);
            wr_end   = 31'(src_e);
        end
    end

    always_comb begin
        cmd.append = (state_reg == S_EXEC) &&
                     (((req_type_reg == sst_pkg::REQ_CREATE) && (count_reg < CNT_MAX)) ||
                      (is_default && (req_len_reg != 30'd0)));
        cmd.remove = (state_reg == S_EXEC) && (req_type_reg == sst_pkg::REQ_DELETE) &&
                     (8'(req_index_reg) < 8'(count_reg));
        cmd.rotate = (state_reg == S_SCAN);
    end

    for (genvar g = 0; g < MAX_SLICES; g++) begin : g_cell
        localparam int NB = (g + 1) % MAX_SLICES;
        sst_cell #(
            .CNT_W (CNT_W),
            .INDEX (g)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .wr_slot   (wr_slot),
            .del_slot  (del_slot),
            .count     (count_reg),
            .root_note (root_reg),
            .wr_start  (wr_start),
            .wr_end    (wr_end),
            .nb_start  (cell_start[NB]),
            .nb_end    (cell_end[NB]),
            .nb_note   (cell_note[NB]),
            .start_q   (cell_start[g]),
            .end_q     (cell_end[g]),
            .note_q    (cell_note[g])
        );
    end

    always_comb begin
        state_next       = state_reg;
        root_next        = cfg_we ? cfg_wdata : root_reg;
        count_next       = count_reg;
        sel_slot_next    = sel_slot_reg;
        sel_flag_next    = sel_flag_reg;
        scan_next        = scan_reg;
        req_type_next    = req_type_reg;
        req_start_next   = req_start_reg;
        req_end_next     = req_end_reg;
        req_index_next   = req_index_reg;
        req_len_next     = req_len_reg;
        req_note_next    = req_note_reg;
        pend_status_next = pend_status_reg;
        pend_idx_next    = pend_idx_reg;
        pend_note_next   = pend_note_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_idx_next       = m_idx_reg;
        m_note_next      = m_note_reg;
        m_total_next     = m_total_reg;
        m_sel_valid_next = m_sel_valid_reg;
        m_sel_idx_next   = m_sel_idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    req_type_next  = s_req_type;
                    req_start_next = s_start_pos;
                    req_end_next   = s_end_pos;
                    req_index_next = s_slice_index;
                    req_len_next   = s_sample_length;
                    req_note_next  = s_note;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC: begin
                pend_status_next = sst_pkg::ST_OK;
                pend_idx_next    = 6'd0;
                pend_note_next   = 7'd0;
                state_next       = S_DONE;
                case (req_type_reg)
                    sst_pkg::REQ_CREATE: begin
                        if (count_reg >= CNT_MAX) begin
                            pend_status_next = sst_pkg::ST_FULL;
                        end else begin
                            pend_idx_next  = 6'(count_reg);
                            pend_note_next = sst_pkg::note_for(root_reg, 8'(count_reg));
                            count_next     = count_reg + CNT_W'(1);
                        end
                    end
                    sst_pkg::REQ_DELETE: begin
                        if (8'(req_index_reg) >= 8'(count_reg)) begin
                            pend_status_next = sst_pkg::ST_IGNORED;
                        end else begin
                            count_next = new_cnt;
                            if (sel_flag_reg && (sel_slot_reg >= new_cnt)) begin
                                sel_slot_next = (new_cnt == '0) ? '0 : new_cnt - CNT_W'(1);
                            end
                            if (new_cnt == '0) begin
                                sel_flag_next = 1'b0;
                                sel_slot_next = '0;
                            end
                        end
                    end
                    sst_pkg::REQ_CLEAR: begin
                        count_next    = '0;
                        sel_flag_next = 1'b0;
                        sel_slot_next = '0;
                    end
                    sst_pkg::REQ_DEFAULT: begin
                        if (req_len_reg == 30'd0) begin
                            pend_status_next = sst_pkg::ST_IGNORED;
                        end else begin
                            pend_note_next = sst_pkg::note_for(root_reg, 8'd0);
                            count_next     = CNT_W'(1);
                            sel_flag_next  = 1'b1;
                            sel_slot_next  = '0;
                        end
                    end
                    sst_pkg::REQ_LOOKUP: begin
                        pend_status_next = sst_pkg::ST_NOT_FOUND;
                        pend_note_next   = req_note_reg;
                        scan_next        = '0;
                        state_next       = S_SCAN;
                    end
                    default: begin
                        pend_status_next = sst_pkg::ST_IGNORED;
                    end
                endcase
            end
            S_SCAN: begin
                // cell 0 holds entry scan_reg; later matches overwrite earlier ones
                if ((scan_reg < count_reg) && (cell_note[0] == req_note_reg)) begin
                    pend_status_next = sst_pkg::ST_OK;
                    pend_idx_next    = 6'(scan_reg);
                end
                scan_next = scan_reg + CNT_W'(1);
                if (scan_reg == SCAN_END) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = pend_status_reg;
                    m_idx_next       = pend_idx_reg;
                    m_note_next      = pend_note_reg;
                    m_total_next     = 7'(count_reg);
                    m_sel_valid_next = sel_flag_reg;
                    m_sel_idx_next   = sel_flag_reg ? 6'(sel_slot_reg) : 6'd0;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            root_reg     <= 7'(sst_pkg::ROOT_RESET);
            count_reg    <= '0;
            sel_slot_reg <= '0;
            sel_flag_reg <= 1'b0;
            scan_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            root_reg     <= root_next;
            count_reg    <= count_next;
            sel_slot_reg <= sel_slot_next;
            sel_flag_reg <= sel_flag_next;
            scan_reg     <= scan_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_type_reg    <= req_type_next;
        req_start_reg   <= req_start_next;
        req_end_reg     <= req_end_next;
        req_index_reg   <= req_index_next;
        req_len_reg     <= req_len_next;
        req_note_reg    <= req_note_next;
        pend_status_reg <= pend_status_next;
        pend_idx_reg    <= pend_idx_next;
        pend_note_reg   <= pend_note_next;
        m_status_reg    <= m_status_next;
        m_idx_reg       <= m_idx_next;
        m_note_reg      <= m_note_next;
        m_total_reg     <= m_total_next;
        m_sel_valid_reg <= m_sel_valid_next;
        m_sel_idx_reg   <= m_sel_idx_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_result_index    = m_idx_reg;
    assign m_result_note     = m_note_reg;
    assign m_slice_total     = m_total_reg;
    assign m_selection_valid = m_sel_valid_reg;
    assign m_selected_index  = m_sel_idx_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("slice count above table size");

    a_sel_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_flag_reg |-> (sel_slot_reg < count_reg))
        else $error("selection points past the last slice");

    a_scan_full_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && state_next != S_SCAN) |-> (scan_reg == SCAN_END))
        else $error("lookup left the ring before a full rotation");

    a_count_only_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(state_reg) != S_EXEC) |-> (count_reg == $past(count_reg)))
        else $error("slice count changed outside request execution");

    a_accept_idle_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == S_EXEC))
        else $error("accepted beat not executed next cycle");
`endif

endmodule

`default_nettype wire

@@ sim/slice_table_checker.sv @@
//------------------------------------------------------------------------------
// slice_table_checker
// Watches the request, result and root-note ports of the slice table, keeps
// its own copy of the table notes, count and selection, and compares every
// result beat field by field against the oldest predicted result.
//------------------------------------------------------------------------------

module slice_table_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [6:0]  cfg_wdata,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire  [2:0]  s_req_type,
    input  wire  [5:0]  s_slice_index,
    input  wire  [29:0] s_sample_length,
    input  wire  [6:0]  s_note,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire  [1:0]  m_status,
    input  wire  [5:0]  m_result_index,
    input  wire  [6:0]  m_result_note,
    input  wire  [6:0]  m_slice_total,
    input  wire         m_selection_valid,
    input  wire  [5:0]  m_selected_index,
    output int          fail_cnt,
    output int          pending,
    output int          checked_cnt,
    output int          full_cnt,
    output int          miss_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] idx;
        logic [6:0] note;
        logic [6:0] total;
        logic       sel_valid;
        logic [5:0] sel_idx;
    } slice_result_t;

    logic [6:0]    root_note_q;
    logic [6:0]    slot_note [sst_pkg::MAX_SLICES_DEF];
    int            slot_count;
    logic [5:0]    sel_slot;
    logic          sel_on;
    slice_result_t expected_results [$];

    // root + slot, pinned at the top note
    function automatic logic [6:0] sat_note(input int slot);
        int sum;
        sum = root_note_q + slot;
        return (sum > sst_pkg::NOTE_MAX) ? 7'(sst_pkg::NOTE_MAX) : 7'(sum);
    endfunction

    // applies one request to the shadow table and returns the result it gives
    function automatic slice_result_t predict_slice_result(input logic [2:0] req,
                                                           input logic [5:0] del_idx,
                                                           input logic [29:0] len,
                                                           input logic [6:0] key);
        slice_result_t r;
        int i;
        r = '0;
        case (req)
            sst_pkg::REQ_CREATE: begin
                if (slot_count >= sst_pkg::MAX_SLICES_DEF) begin
                    r.status = sst_pkg::ST_FULL;
                end else begin
                    slot_note[slot_count] = sat_note(slot_count);
                    r.idx  = 6'(slot_count);
                    r.note = slot_note[slot_count];
                    slot_count++;
                end
            end
            sst_pkg::REQ_DELETE: begin
                if (int'(del_idx) >= slot_count) begin
                    r.status = sst_pkg::ST_IGNORED;
                end else begin
                    // survivors above the hole get renumbered notes
                    for (i = del_idx; i + 1 < slot_count; i++)
                        slot_note[i] = sat_note(i);
                    slot_count--;
                    if (sel_on && int'(sel_slot) >= slot_count)
                        sel_slot = (slot_count > 0) ? 6'(slot_count - 1) : '0;
                    if (slot_count == 0) begin
                        sel_on   = 1'b0;
                        sel_slot = '0;
                    end
                end
            end
            sst_pkg::REQ_CLEAR: begin
                slot_count = 0;
                sel_on     = 1'b0;
                sel_slot   = '0;
            end
            sst_pkg::REQ_DEFAULT: begin
                if (len == '0) begin
                    r.status = sst_pkg::ST_IGNORED;
                end else begin
                    slot_note[0] = sat_note(0);
                    slot_count   = 1;
                    r.note       = slot_note[0];
                    sel_on       = 1'b1;
                    sel_slot     = '0;
                end
            end
            sst_pkg::REQ_LOOKUP: begin
                r.status = sst_pkg::ST_NOT_FOUND;
                r.note   = key;
                for (i = 0; i < slot_count; i++) begin
                    if (slot_note[i] == key) begin
                        r.status = sst_pkg::ST_OK;
                        r.idx    = 6'(i);
                    end
                end
            end
            default: begin
                r.status = sst_pkg::ST_IGNORED;
            end
        endcase
        r.total     = 7'(slot_count);
        r.sel_valid = sel_on;
        r.sel_idx   = sel_on ? sel_slot : '0;
        return r;
    endfunction

    task automatic cmp_field(input string tag, input int want, input int got);
        if (want != got) begin
            fail_cnt++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        slice_result_t want;
        if (!aresetn) begin
            root_note_q = 7'(sst_pkg::ROOT_RESET);
            slot_count  = 0;
            sel_on      = 1'b0;
            sel_slot    = '0;
            expected_results.delete();
            fail_cnt    = 0;
            pending     = 0;
            checked_cnt = 0;
            full_cnt    = 0;
            miss_cnt    = 0;
        end else begin
            // result side first: a new request may be taken on the same edge
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fail_cnt++;
                    $display("%0t ns: result beat with nothing expected, status %0d",
                             $time, m_status);
                end else begin
                    want = expected_results.pop_front();
                    checked_cnt++;
                    if (want.status == sst_pkg::ST_FULL)
                        full_cnt++;
                    if (want.status == sst_pkg::ST_NOT_FOUND)
                        miss_cnt++;
                    cmp_field("status", want.status, m_status);
                    cmp_field("result_index", want.idx, m_result_index);
                    cmp_field("result_note", want.note, m_result_note);
                    cmp_field("slice_total", want.total, m_slice_total);
                    cmp_field("selection_valid", want.sel_valid, m_selection_valid);
                    cmp_field("selected_index", want.sel_idx, m_selected_index);
                end
            end
            if (cfg_we)
                root_note_q = cfg_wdata;
            if (s_valid && s_ready)
                expected_results.push_back(predict_slice_result(s_req_type, s_slice_index,
                                                                s_sample_length, s_note));
            pending = expected_results.size();
        end
    end

endmodule

@@ sim/tb_sample_slice_table_unit.sv @@
//------------------------------------------------------------------------------
// tb_sample_slice_table_unit
// Drives directed and random slice requests into the slice table under
// random gaps and result stalls, moves the root note through several values
// between phases, and reports the verdict from the checker's failure count.
//------------------------------------------------------------------------------

module tb_sample_slice_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam int         TIMEOUT_NS    = 7_000_000;
    localparam int         DRAIN_CYCLES  = sst_pkg::MAX_SLICES_DEF + 16;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_we          = 1'b0;
    logic [6:0]  cfg_wdata       = '0;
    logic        s_valid         = 1'b0;
    logic [2:0]  s_req_type      = '0;
    logic [29:0] s_start_pos     = '0;
    logic [29:0] s_end_pos       = '0;
    logic [5:0]  s_slice_index   = '0;
    logic [29:0] s_sample_length = '0;
    logic [6:0]  s_note          = '0;
    logic        m_ready         = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [1:0]  m_status;
    wire  [5:0]  m_result_index;
    wire  [6:0]  m_result_note;
    wire  [6:0]  m_slice_total;
    wire         m_selection_valid;
    wire  [5:0]  m_selected_index;

    int         fail_cnt;
    int         pending;
    int         checked_cnt;
    int         full_cnt;
    int         miss_cnt;
    int         n_sent   = 0;
    bit         no_gaps  = 1'b0;
    logic [6:0] root_now = 7'(sst_pkg::ROOT_RESET);

    sample_slice_table_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_start_pos       (s_start_pos),
        .s_end_pos         (s_end_pos),
        .s_slice_index     (s_slice_index),
        .s_sample_length   (s_sample_length),
        .s_note            (s_note),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_result_index    (m_result_index),
        .m_result_note     (m_result_note),
        .m_slice_total     (m_slice_total),
        .m_selection_valid (m_selection_valid),
        .m_selected_index  (m_selected_index)
    );

    slice_table_checker chk (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_slice_index     (s_slice_index),
        .s_sample_length   (s_sample_length),
        .s_note            (s_note),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_result_index    (m_result_index),
        .m_result_note     (m_result_note),
        .m_slice_total     (m_slice_total),
        .m_selection_valid (m_selection_valid),
        .m_selected_index  (m_selected_index),
        .fail_cnt          (fail_cnt),
        .pending           (pending),
        .checked_cnt       (checked_cnt),
        .full_cnt          (full_cnt),
        .miss_cnt          (miss_cnt)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result-side backpressure: short stalls mostly, some long, some long open runs
    initial begin : result_sink
        int run;
        int stall;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            m_ready <= 1'b0;
            repeat (stall) @(posedge aclk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly notes the table can hold under the current root, some anywhere
    function automatic logic [6:0] pick_note();
        int n;
        n = root_now + $urandom_range(0, 70);
        if ($urandom_range(0, 9) < 3)
            return 7'($urandom_range(0, 127));
        return (n > sst_pkg::NOTE_MAX) ? 7'(sst_pkg::NOTE_MAX) : 7'(n);
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38)
            return sst_pkg::REQ_CREATE;
        if (r < 63)
            return sst_pkg::REQ_LOOKUP;
        if (r < 83)
            return sst_pkg::REQ_DELETE;
        if (r < 86)
            return sst_pkg::REQ_CLEAR;
        if (r < 94)
            return sst_pkg::REQ_DEFAULT;
        return 3'(REQ_UNUSED_LO + $urandom_range(0, 2));
    endfunction

    // one request beat; valid stays up into the next call when no gap follows
    task automatic send_req(input logic [2:0] req, input logic [29:0] sp, input logic [29:0] ep,
                            input logic [5:0] di, input logic [29:0] len, input logic [6:0] nt);
        int gap;
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_start_pos     <= sp;
        s_end_pos       <= ep;
        s_slice_index   <= di;
        s_sample_length <= len;
        s_note          <= nt;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_kind(input logic [2:0] req);
        logic [29:0] sp;
        logic [29:0] ep;
        logic [29:0] len;
        logic [5:0]  di;
        logic [6:0]  nt;
        int          r;
        sp  = 30'($urandom);
        ep  = 30'($urandom);
        len = 30'($urandom);
        di  = 6'($urandom);
        nt  = 7'($urandom);
        r   = $urandom_range(0, 3);
        case (req)
            sst_pkg::REQ_CREATE: begin
                // short spans in both directions, else anything
                if (r == 0)
                    ep = sp + 30'($urandom_range(0, 63));
                else if (r == 1)
                    ep = sp - 30'($urandom_range(0, 63));
            end
            sst_pkg::REQ_DELETE: begin
                if (r < 2)
                    di = 6'($urandom_range(0, 7));
            end
            sst_pkg::REQ_DEFAULT: begin
                if (r == 0)
                    len = '0;
                else if (r == 1)
                    len = 30'($urandom_range(1, 63));
            end
            sst_pkg::REQ_LOOKUP: begin
                nt = pick_note();
            end
            default: ;
        endcase
        send_req(req, sp, ep, di, len, nt);
    endtask

    // fresh table, then enough creates to run into the full case about half the time
    task automatic fill_table();
        send_req(sst_pkg::REQ_DEFAULT, 30'($urandom), 30'($urandom), 6'($urandom),
                 30'($urandom_range(1, 30'h3FFF_FFFF)), 7'($urandom));
        repeat ($urandom_range(55, 70)) send_kind(sst_pkg::REQ_CREATE);
        repeat (3) send_kind(sst_pkg::REQ_LOOKUP);
    endtask

    task automatic run_phase(input int n_items);
        int first;
        int r;
        first   = n_sent;
        no_gaps = 1'b0;
        fill_table();
        while (n_sent - first < n_items) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 6)
                fill_table();
            else if (r < 22)
                repeat (6) send_kind(sst_pkg::REQ_LOOKUP);
            else if (r < 34)
                repeat ($urandom_range(2, 6)) send_kind(sst_pkg::REQ_DELETE);
            else
                repeat (10) send_kind(pick_kind());
        end
        no_gaps = 1'b0;
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain(input int extra);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_root(input logic [6:0] v);
        drain(4);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        root_now = v;
    endtask

    initial begin : stim
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table corner cases
        send_req(sst_pkg::REQ_LOOKUP, '0, '0, '0, '0, 7'd36);
        send_req(sst_pkg::REQ_DELETE, '0, '0, '0, '0, '0);
        send_req(sst_pkg::REQ_CLEAR, '0, '0, '0, '0, '0);
        // short, reversed, reversed-and-short, short at the top of the range
        send_req(sst_pkg::REQ_CREATE, '0, '0, '0, '0, '0);
        send_req(sst_pkg::REQ_CREATE, 30'h3FFF_FFFF, '0, '0, '0, '0);
        send_req(sst_pkg::REQ_CREATE, 30'd100, 30'd50, '0, '0, '0);
        send_req(sst_pkg::REQ_CREATE, 30'h3FFF_FFC0, 30'h3FFF_FFFF, '0, '0, '0);
        send_req(sst_pkg::REQ_LOOKUP, '0, '0, '0, '0, 7'd38);
        send_req(sst_pkg::REQ_LOOKUP, '0, '0, '0, '0, 7'h7F);
        send_req(sst_pkg::REQ_LOOKUP, '0, '0, '0, '0, 7'd0);
        // deletes past the end, then one from the middle
        send_req(sst_pkg::REQ_DELETE, '0, '0, 6'h3F, '0, '0);
        send_req(sst_pkg::REQ_DELETE, '0, '0, 6'd4, '0, '0);
        send_req(sst_pkg::REQ_DELETE, '0, '0, 6'd1, '0, '0);
        send_req(sst_pkg::REQ_LOOKUP, '0, '0, '0, '0, 7'd39);
        send_req(sst_pkg::REQ_DEFAULT, '0, '0, '0, '0, '0);
        send_req(sst_pkg::REQ_DEFAULT, '0, '0, '0, 30'h3FFF_FFFF, '0);
        send_req(sst_pkg::REQ_CREATE, 30'h3FFF_FFFF, 30'h3FFF_FFFF, '0, '0, '0);
        send_req(sst_pkg::REQ_DELETE, '0, '0, 6'd1, '0, '0);
        send_req(sst_pkg::REQ_DEFAULT, '0, '0, '0, 30'd1, '0);
        // last slice goes, selection is dropped
        send_req(sst_pkg::REQ_DELETE, '0, '0, '0, '0, '0);
        send_req(REQ_UNUSED_LO, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 6'h3F, 30'h3FFF_FFFF, 7'h7F);
        send_req(3'(REQ_UNUSED_LO + 1), '0, '0, '0, '0, '0);
        send_req(3'(REQ_UNUSED_LO + 2), 30'h3FFF_FFFF, 30'h3FFF_FFFF, 6'h3F, 30'h3FFF_FFFF,
                 7'h7F);

        set_root(7'd0);
        run_phase(260);
        set_root(7'd127);
        run_phase(260);
        set_root(7'd100);
        run_phase(260);
        set_root(7'($urandom_range(1, 126)));
        run_phase(260);
        drain(DRAIN_CYCLES);

        $display("Summary: %0d requests over five root-note settings, %0d results compared",
                 n_sent, checked_cnt);
        $display("Summary: %0d table-full and %0d note-miss results, %0d field mismatches",
                 full_cnt, miss_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/sst_pkg.sv
src/sst_cell.sv
src/sample_slice_table_unit.sv
sim/slice_table_checker.sv
sim/tb_sample_slice_table_unit.sv
